/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl files of the display refresh core
// no dependencies; pulled in with an include by the files that assert
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, muted while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion without a reset guard
`define ASSERT_ALW(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/cldr_pkg.sv */
// shared types and constants of the display refresh core
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package cldr_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_PUT     = 2'd1;
    localparam logic [1:0] OP_LOCATE  = 2'd2;
    localparam logic [1:0] OP_REFRESH = 2'd3;

    // command kinds carried from front to back
    typedef logic [1:0] t_kind;
    localparam t_kind K_CLEAR   = 2'd0;
    localparam t_kind K_PUT     = 2'd1;
    localparam t_kind K_REFRESH = 2'd2;

    // configuration register indexes
    localparam logic REG_LINE0 = 1'b0;
    localparam logic REG_LINE1 = 1'b1;

    localparam logic [6:0] LINE0_RST = 7'd0;
    localparam logic [6:0] LINE1_RST = 7'd64;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] SET_ADDR   = 8'h80;

    // default geometry and queue depth
    localparam int DEF_ROWS = 2;
    localparam int DEF_COLS = 16;
    localparam int Q_DEPTH  = 4;

endpackage

`default_nettype wire

/* hw/rtl/cldr_front.sv */
// front end: accepts items, tracks write position and dirty flag, queues commands
// depends on cldr_pkg
`timescale 1ns / 1ps
`default_nettype none

module cldr_front
    import cldr_pkg::*;
#(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS,
    localparam int CELLS = ROWS * COLS,
    localparam int CELL_W = $clog2(CELLS),
    localparam int Q_W = 2 + CELL_W + 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [1:0]       i_op,
    input  wire logic [7:0]       i_char_code,
    input  wire logic             i_row,
    input  wire logic [3:0]       i_col,
    input  wire logic             i_full,
    output logic                  o_push,
    output logic [Q_W-1:0]        o_push_data
);

    logic [CELL_W-1:0] r_wpos, n_wpos;
    logic              r_dirty, n_dirty;
    logic              accept;
    logic              in_range;
    logic [CELL_W-1:0] loc_pos;
    logic [CELL_W-1:0] next_pos;
    t_kind             kind;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    // locate target and range check
    assign in_range = (32'(i_row) < ROWS) && (32'(i_col) < COLS);
    assign loc_pos  = CELL_W'(i_row ? COLS : 0) + CELL_W'(i_col);
    assign next_pos = (r_wpos == CELL_W'(CELLS - 1)) ? '0 : r_wpos + CELL_W'(1);

    // classify the item and update position tracking
    always_comb begin
        n_wpos  = r_wpos;
        n_dirty = r_dirty;
        o_push  = 1'b0;
        kind    = K_CLEAR;
        if (accept) begin
            case (i_op)
                OP_CLEAR: begin
                    o_push  = 1'b1;
                    kind    = K_CLEAR;
                    n_wpos  = '0;
                    n_dirty = 1'b1;
                end
                OP_PUT: begin
                    o_push  = 1'b1;
                    kind    = K_PUT;
                    n_wpos  = next_pos;
                    n_dirty = 1'b1;
                end
                OP_LOCATE: begin
                    if (in_range) begin
                        n_wpos = loc_pos;
                    end
                end
                OP_REFRESH: begin
                    if (r_dirty) begin
                        o_push  = 1'b1;
                        kind    = K_REFRESH;
                        n_wpos  = '0;
                        n_dirty = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_push_data = {kind, r_wpos, i_char_code};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos  <= '0;
            r_dirty <= 1'b0;
        end else begin
            r_wpos  <= n_wpos;
            r_dirty <= n_dirty;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/cldr_fifo.sv */
// short command queue between front and back
// depends on cldr_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cldr_fifo
    import cldr_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = Q_DEPTH,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_valid,
    output logic [W-1:0]      o_data
);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    `ASSERT_CLK(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_full, "push into full queue")
    `ASSERT_CLK(a_no_underflow, i_clk, i_rst_n, i_pop |-> o_valid, "pop from empty queue")

endmodule

`default_nettype wire

/* hw/rtl/cldr_back.sv */
// back end: frame and shadow stores, line registers and the refresh walker
// depends on cldr_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cldr_back
    import cldr_pkg::*;
#(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS,
    localparam int CELLS = ROWS * COLS,
    localparam int CELL_W = $clog2(CELLS),
    localparam int COL_W = $clog2(COLS),
    localparam int Q_W = 2 + CELL_W + 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_idx,
    input  wire logic [6:0]     i_cfg_data,
    input  wire logic           i_q_valid,
    input  wire logic [Q_W-1:0] i_q_data,
    output logic                o_q_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic                o_rs,
    output logic [7:0]          o_bus_byte,
    output logic                o_last
);

    // walker states
    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_READ = 3'd1;
    localparam logic [2:0] B_CMP  = 3'd2;
    localparam logic [2:0] B_ADDR = 3'd3;
    localparam logic [2:0] B_DATA = 3'd4;
    localparam logic [2:0] B_EOL  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [CELL_W-1:0] r_idx, n_idx;
    logic [COL_W-1:0]  r_col, n_col;
    logic              r_line, n_line;
    logic              r_skip, n_skip;
    logic [7:0]        r_cell, n_cell;
    logic [6:0]        r_line0, r_line1;

    logic [7:0]        r_frame_mem [CELLS];
    logic [7:0]        r_shadow_mem [CELLS];
    logic [CELLS-1:0]  r_frame_vld, r_shadow_vld;
    logic [7:0]        r_frame_rd, r_shadow_rd;
    logic              r_frame_rd_v, r_shadow_rd_v;

    logic              r_out_vld;
    logic              r_out_rs;
    logic [7:0]        r_out_byte;
    logic              r_out_last;

    t_kind             q_kind;
    logic [CELL_W-1:0] q_addr;
    logic [7:0]        q_char;
    logic              frame_we, frame_clr, shadow_we;
    logic              out_load, out_rs, out_last;
    logic [7:0]        out_byte;
    logic              slot_free;
    logic [7:0]        frm_ch, shad;
    logic              changed, col_end, line_last;
    logic [6:0]        line_base;
    logic [7:0]        cell_addr, eol_addr;

    assign {q_kind, q_addr, q_char} = i_q_data;

    // effective cell values, unwritten entries read as spaces
    assign frm_ch    = r_frame_rd_v ? r_frame_rd : SPACE_CHAR;
    assign shad      = r_shadow_rd_v ? r_shadow_rd : SPACE_CHAR;
    assign changed   = (frm_ch != shad);
    assign col_end   = (r_col == COL_W'(COLS - 1));
    assign line_last = (r_line == 1'(ROWS - 1));
    assign line_base = r_line ? r_line1 : r_line0;
    assign cell_addr = SET_ADDR + {1'b0, line_base} + 8'(r_col);
    assign eol_addr  = SET_ADDR + {1'b0, (line_last ? r_line0 : r_line1)};
    assign slot_free = !r_out_vld || i_ready;

    // walker sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_col     = r_col;
        n_line    = r_line;
        n_skip    = r_skip;
        n_cell    = r_cell;
        o_q_pop   = 1'b0;
        frame_we  = 1'b0;
        frame_clr = 1'b0;
        shadow_we = 1'b0;
        out_load  = 1'b0;
        out_rs    = 1'b0;
        out_byte  = eol_addr;
        out_last  = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    case (q_kind)
                        K_CLEAR: frame_clr = 1'b1;
                        K_PUT:   frame_we  = 1'b1;
                        K_REFRESH: begin
                            n_idx   = '0;
                            n_col   = '0;
                            n_line  = 1'b0;
                            n_skip  = 1'b0;
                            n_state = B_READ;
                        end
                        default: ;
                    endcase
                end
            end
            B_READ: begin
                n_state = B_CMP;
            end
            B_CMP: begin
                if (changed) begin
                    shadow_we = 1'b1;
                    n_cell    = frm_ch;
                    n_state   = r_skip ? B_ADDR : B_DATA;
                end else begin
                    n_skip = 1'b1;
                    if (col_end) begin
                        n_state = B_EOL;
                    end else begin
                        n_idx   = r_idx + CELL_W'(1);
                        n_col   = r_col + COL_W'(1);
                        n_state = B_READ;
                    end
                end
            end
            B_ADDR: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    out_byte = cell_addr;
                    n_skip   = 1'b0;
                    n_state  = B_DATA;
                end
            end
            B_DATA: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    out_rs   = 1'b1;
                    out_byte = r_cell;
                    if (col_end) begin
                        n_state = B_EOL;
                    end else begin
                        n_idx   = r_idx + CELL_W'(1);
                        n_col   = r_col + COL_W'(1);
                        n_state = B_READ;
                    end
                end
            end
            B_EOL: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    out_byte = eol_addr;
                    out_last = line_last;
                    if (line_last) begin
                        n_state = B_IDLE;
                    end else begin
                        n_line  = 1'b1;
                        n_col   = '0;
                        n_idx   = r_idx + CELL_W'(1);
                        n_skip  = 1'b0;
                        n_state = B_READ;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_idx   <= '0;
            r_col   <= '0;
            r_line  <= 1'b0;
            r_skip  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_col   <= n_col;
            r_line  <= n_line;
            r_skip  <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    // line address registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line0 <= LINE0_RST;
            r_line1 <= LINE1_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LINE0: r_line0 <= i_cfg_data;
                REG_LINE1: r_line1 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame and shadow memories, registered reads at the walk index
    always_ff @(posedge i_clk) begin
        if (frame_we) begin
            r_frame_mem[q_addr] <= q_char;
        end
        r_frame_rd <= r_frame_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (shadow_we) begin
            r_shadow_mem[r_idx] <= frm_ch;
        end
        r_shadow_rd <= r_shadow_mem[r_idx];
    end

    // written flags per cell; a clear drops all frame flags at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_vld  <= '0;
            r_shadow_vld <= '0;
        end else begin
            if (frame_clr) begin
                r_frame_vld <= '0;
            end else if (frame_we) begin
                r_frame_vld[q_addr] <= 1'b1;
            end
            if (shadow_we) begin
                r_shadow_vld[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame_rd_v  <= r_frame_vld[r_idx];
        r_shadow_rd_v <= r_shadow_vld[r_idx];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_rs   <= out_rs;
            r_out_byte <= out_byte;
            r_out_last <= out_last;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_rs       = r_out_rs;
    assign o_bus_byte = r_out_byte;
    assign o_last     = r_out_last;

    `ASSERT_CLK(a_last_is_cmd, i_clk, i_rst_n, (o_valid && o_last) |-> !o_rs, "last on data byte")
    `ASSERT_CLK(a_cmp_rd, i_clk, i_rst_n, (r_state == B_CMP) |-> $past(r_state == B_READ), "no read")
    `ASSERT_CLK(a_pop_idle, i_clk, i_rst_n, o_q_pop |-> (r_state == B_IDLE), "pop mid refresh")

endmodule

`default_nettype wire

/* hw/rtl/char_lcd_diff_refresh_core.sv */
// character display frame store with shadow copy and differential refresh
// items are taken one per cycle while the queue is not full; clear, put and refresh
// pass a four-entry queue; clear and put are done as popped; a refresh walks every
// cell with one read port per store, reading and comparing each and sending changed
// cells and address bytes; no queued item runs meanwhile; sync active-low reset;
// per-cell written flags make both stores read as spaces
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_diff_refresh_core
    import cldr_pkg::*;
#(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS,
    parameter int QDEPTH = Q_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_row,
    input  wire logic [3:0] i_col,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_rs,
    output logic [7:0]      o_bus_byte,
    output logic            o_last,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [6:0] i_cfg_data
);

    localparam int CELL_W = $clog2(ROWS * COLS);
    localparam int Q_W = 2 + CELL_W + 8;

    logic           q_full, q_push, q_pop, q_valid;
    logic [Q_W-1:0] q_in, q_out;

    // item classification and position tracking
    cldr_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_char_code (i_char_code),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_push_data (q_in)
    );

    // command queue
    cldr_fifo #(.W(Q_W), .DEPTH(QDEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // stores and refresh walker
    cldr_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_q_data   (q_out),
        .o_q_pop    (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rs       (o_rs),
        .o_bus_byte (o_bus_byte),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// self-checking bench for the character display diff-refresh core
// depends on cldr_pkg and char_lcd_diff_refresh_core; runs stand-alone
`timescale 1ns / 1ps

module tb_top;
    import cldr_pkg::*;

    localparam int ROWS          = DEF_ROWS;
    localparam int COLS          = DEF_COLS;
    localparam int CELLS         = ROWS * COLS;
    localparam int SETTLE_CYCLES = 400;
    localparam int STALL_LIMIT   = 5000;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] char_code;
        logic       row;
        logic [3:0] col;
    } edit_item_t;

    typedef struct packed {
        logic       rs;
        logic [7:0] bus_byte;
        logic       last;
    } bus_write_t;

    // dut signals, the inputs all known from time zero
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [1:0] i_op        = OP_CLEAR;
    logic [7:0] i_char_code = 8'd0;
    logic       i_row       = 1'b0;
    logic [3:0] i_col       = 4'd0;
    logic       i_ready     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_idx   = REG_LINE0;
    logic [6:0] i_cfg_data  = 7'd0;
    logic       o_ready;
    logic       o_valid;
    logic       o_rs;
    logic [7:0] o_bus_byte;
    logic       o_last;

    // mirror of the display state
    logic [7:0] frame_mirror  [CELLS];
    logic [7:0] shadow_mirror [CELLS];
    logic [6:0] line_base_mirror [ROWS];
    int         pos_mirror;
    logic       dirty_mirror;

    edit_item_t items_todo[$];
    bus_write_t bytes_due[$];
    int         idle_pct = 21;
    int         mismatches = 0;
    int         quiet_cycles = 0;

    char_lcd_diff_refresh_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_char_code (i_char_code),
        .i_row       (i_row),
        .i_col       (i_col),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rs        (o_rs),
        .o_bus_byte  (o_bus_byte),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // set-address command: 0x80 plus line base plus column, wrapping at 256
    function automatic void push_address(int line, int col, logic last);
        bus_write_t w;
        int         sum;
        sum = SET_ADDR + line_base_mirror[line] + col;
        w.rs = 1'b0;
        w.bus_byte = sum[7:0];
        w.last = last;
        bytes_due.push_back(w);
    endfunction

    // apply one accepted item to the mirror and queue the bus writes it causes
    function automatic void apply_edit(edit_item_t it);
        bus_write_t w;
        int         line;
        int         c;
        int         idx;
        int         skipped;
        case (it.op)
            OP_CLEAR: begin
                foreach (frame_mirror[k]) frame_mirror[k] = SPACE_CHAR;
                pos_mirror = 0;
                dirty_mirror = 1'b1;
            end
            OP_PUT: begin
                frame_mirror[pos_mirror] = it.char_code;
                pos_mirror = (pos_mirror >= CELLS - 1) ? 0 : pos_mirror + 1;
                dirty_mirror = 1'b1;
            end
            OP_LOCATE: begin
                if (it.row < ROWS && it.col < COLS) pos_mirror = it.row * COLS + it.col;
            end
            OP_REFRESH: begin
                if (dirty_mirror) begin
                    for (line = 0; line < ROWS; line++) begin
                        skipped = 0;
                        for (c = 0; c < COLS; c++) begin
                            idx = line * COLS + c;
                            if (frame_mirror[idx] != shadow_mirror[idx]) begin
                                if (skipped != 0) begin
                                    push_address(line, c, 1'b0);
                                    skipped = 0;
                                end
                                w.rs = 1'b1;
                                w.bus_byte = frame_mirror[idx];
                                w.last = 1'b0;
                                bytes_due.push_back(w);
                            end else begin
                                skipped++;
                            end
                        end
                        // line end: point at the next line, wrapping to line 0
                        if (line + 1 < ROWS) push_address(line + 1, 0, 1'b0);
                        else push_address(0, 0, 1'b1);
                    end
                    shadow_mirror = frame_mirror;
                    pos_mirror = 0;
                    dirty_mirror = 1'b0;
                end
            end
        endcase
    endfunction

    function automatic edit_item_t random_edit(bit puts_only);
        edit_item_t it;
        int         roll;
        it.char_code = 8'($urandom_range(255));
        it.row = 1'($urandom_range(1));
        it.col = 4'($urandom_range(15));
        roll = puts_only ? 20 : $urandom_range(99);
        if (roll < 6) it.op = OP_CLEAR;
        else if (roll < 60) it.op = OP_PUT;
        else if (roll < 85) it.op = OP_LOCATE;
        else it.op = OP_REFRESH;
        // spaces and a few letters keep many cells equal to the shadow
        if ($urandom_range(2) != 0)
            it.char_code = ($urandom_range(1) == 0) ? SPACE_CHAR : 8'h41 + 8'($urandom_range(2));
        return it;
    endfunction

    task automatic push_edit(logic [1:0] op, logic [7:0] ch, logic row, logic [3:0] col);
        edit_item_t it;
        it.op = op;
        it.char_code = ch;
        it.row = row;
        it.col = col;
        items_todo.push_back(it);
    endtask

    // bursts of edits, each closed by a refresh; now and then a long put run to wrap
    task automatic add_random(int count);
        edit_item_t it;
        int         made;
        int         burst;
        bit         long_run;
        made = 0;
        while (made < count) begin
            long_run = ($urandom_range(9) == 0);
            burst = long_run ? 34 : $urandom_range(1, 10);
            for (int k = 0; k < burst && made < count; k++) begin
                items_todo.push_back(random_edit(long_run));
                made++;
            end
            if (made < count) begin
                it = random_edit(1'b0);
                it.op = OP_REFRESH;
                items_todo.push_back(it);
                made++;
            end
        end
    endtask

    // hold off until everything sent has come back, then let the core settle
    task automatic drain();
        do @(negedge i_clk);
        while (items_todo.size() != 0 || i_valid || bytes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_line_base(logic idx, logic [6:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        line_base_mirror[idx] = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic flag_error(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    // item driver: predicts on acceptance, then loads the next pending item
    always @(posedge i_clk) begin
        edit_item_t nxt;
        logic       send;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) apply_edit({i_op, i_char_code, i_row, i_col});
            if (!i_valid || o_ready) begin
                send = items_todo.size() != 0 && $urandom_range(99) >= idle_pct;
                if (send) begin
                    nxt = items_todo.pop_front();
                    i_op        <= nxt.op;
                    i_char_code <= nxt.char_code;
                    i_row       <= nxt.row;
                    i_col       <= nxt.col;
                end
                i_valid <= send;
            end
        end
    end

    // bus monitor: compare each accepted write with the oldest expected one
    always @(posedge i_clk) begin
        bus_write_t got;
        bus_write_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got.rs = o_rs;
                got.bus_byte = o_bus_byte;
                got.last = o_last;
                if (bytes_due.size() == 0) begin
                    flag_error($sformatf("unexpected write rs=%0b byte=%02h last=%0b",
                                         got.rs, got.bus_byte, got.last));
                end else begin
                    want = bytes_due.pop_front();
                    if (got.rs !== want.rs || got.bus_byte !== want.bus_byte
                        || got.last !== want.last)
                        flag_error($sformatf(
                            "write mismatch exp rs=%0b byte=%02h last=%0b got rs=%0b byte=%02h last=%0b",
                            want.rs, want.bus_byte, want.last,
                            got.rs, got.bus_byte, got.last));
                end
            end
            i_ready <= $urandom_range(99) >= idle_pct;
        end
    end

    // watchdog on cycles with work outstanding but no handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
            || (bytes_due.size() == 0 && items_todo.size() == 0 && !i_valid)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        foreach (frame_mirror[k]) begin
            frame_mirror[k] = SPACE_CHAR;
            shadow_mirror[k] = SPACE_CHAR;
        end
        line_base_mirror[0] = LINE0_RST;
        line_base_mirror[1] = LINE1_RST;
        pos_mirror = 0;
        dirty_mirror = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: refresh while clean, byte extremes, put wrap, skips, clear
        push_edit(OP_REFRESH, 8'hFF, 1'b1, 4'hF);
        push_edit(OP_PUT,     8'h00, 1'b0, 4'h0);
        push_edit(OP_PUT,     8'hFF, 1'b1, 4'hF);
        push_edit(OP_LOCATE,  8'h00, 1'b1, 4'hF);
        push_edit(OP_PUT,     8'hAA, 1'b0, 4'h0);
        push_edit(OP_PUT,     8'h55, 1'b0, 4'h0);
        push_edit(OP_LOCATE,  8'hFF, 1'b0, 4'h8);
        push_edit(OP_PUT,     8'h7E, 1'b1, 4'h3);
        push_edit(OP_REFRESH, 8'h00, 1'b0, 4'h0);
        push_edit(OP_LOCATE,  8'h00, 1'b1, 4'h0);
        push_edit(OP_REFRESH, 8'h00, 1'b0, 4'h0);
        // put of the char already shown: dirty but nothing changed
        push_edit(OP_LOCATE,  8'h00, 1'b0, 4'h2);
        push_edit(OP_PUT,     SPACE_CHAR, 1'b0, 4'h0);
        push_edit(OP_REFRESH, 8'h00, 1'b0, 4'h0);
        push_edit(OP_CLEAR,   8'h00, 1'b0, 4'h0);
        push_edit(OP_REFRESH, 8'h00, 1'b0, 4'h0);
        push_edit(OP_CLEAR,   8'hFF, 1'b1, 4'hF);
        push_edit(OP_REFRESH, 8'hFF, 1'b1, 4'hF);
        drain();

        // both bases at the top: set-address bytes wrap past 255
        write_line_base(REG_LINE0, 7'd127);
        write_line_base(REG_LINE1, 7'd127);
        add_random(100);
        drain();

        // long stretch with no idling on either side
        idle_pct = 0;
        write_line_base(REG_LINE0, 7'd0);
        write_line_base(REG_LINE1, 7'd127);
        add_random(110);
        drain();

        idle_pct = 21;
        write_line_base(REG_LINE0, 7'd127);
        write_line_base(REG_LINE1, 7'd0);
        add_random(100);
        drain();

        write_line_base(REG_LINE0, 7'($urandom_range(127)));
        write_line_base(REG_LINE1, 7'($urandom_range(127)));
        add_random(100);
        drain();

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
